/* sv/assert_macros.svh */
// Assertion macros shared by the hue-wheel texel RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that must hold at every sampled edge.
`define HCW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);
// Antecedent in this cycle implies consequent in the next.
`define HCW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* sv/hcw_pkg.sv */
// Package for the hue-wheel texel core: widths, fixed-point constants,
// the CORDIC arctangent table and the classified-texel struct. No dependencies.
`default_nettype none
package hcw_pkg;
	localparam int WHEEL_SIZE_DEF    = 128;
	localparam int FRACTION_BITS_DEF = 16;

	localparam int COORD_W      = 7;
	localparam int BYTE_W       = 8;
	localparam int OFF_W        = 14;  // signed half-texel offset, sizes up to 4096
	localparam int GUARD_BITS   = 16;
	localparam int CW           = 32;  // CORDIC x/y width
	localparam int ZW           = 29;  // angle accumulator width, hue units * 2^24
	localparam int ANGLE_BITS   = 24;
	localparam int CORDIC_STEPS = 24;

	localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
	localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;
	localparam logic [BYTE_W-1:0] BYTE_MIN = 8'h00;

	// Half-plane correction applied to the CORDIC angle
	localparam logic [1:0] BASE_ZERO = 2'd0;
	localparam logic [1:0] BASE_POS  = 2'd1;
	localparam logic [1:0] BASE_NEG  = 2'd2;

	// Hue sectors
	localparam logic [2:0] SECTOR_0 = 3'd0;
	localparam logic [2:0] SECTOR_1 = 3'd1;
	localparam logic [2:0] SECTOR_2 = 3'd2;
	localparam logic [2:0] SECTOR_3 = 3'd3;
	localparam logic [2:0] SECTOR_4 = 3'd4;
	localparam logic [2:0] SECTOR_5 = 3'd5;

	// atan(2^-i) * 3/pi * 2^24, rounded
	localparam logic [ANGLE_BITS-1:0] ATAN_HUE [CORDIC_STEPS] = '{
		24'd12582912, 24'd7428127, 24'd3924818, 24'd1992299, 24'd1000016, 24'd500495,
		24'd250309, 24'd125162, 24'd62582, 24'd31291, 24'd15646, 24'd7823,
		24'd3911, 24'd1956, 24'd978, 24'd489, 24'd244, 24'd122,
		24'd61, 24'd31, 24'd15, 24'd8, 24'd4, 24'd2
	};

	typedef struct packed {
		logic                    centre;
		logic                    axis;
		logic [1:0]              base;
		logic signed [OFF_W-1:0] x0;
		logic signed [OFF_W-1:0] y0;
	} texel_cls_t;
endpackage
`default_nettype wire

/* sv/hcw_front.sv */
// Front end: accepts a texel coordinate and classifies it (offsets,
// half plane, centre and axis cases). Uses hcw_pkg.
`default_nettype none
module hcw_front import hcw_pkg::*; #(
	parameter int WHEEL_SIZE = WHEEL_SIZE_DEF
) (
	input  wire logic [COORD_W-1:0] column,
	input  wire logic [COORD_W-1:0] row,
	input  wire logic               texel_valid,
	output logic                    texel_ready,
	output logic                    cls_valid,
	output texel_cls_t              cls,
	input  wire logic               cls_ready
);
	localparam logic signed [OFF_W-1:0] TS_S = OFF_W'(WHEEL_SIZE);

	logic signed [OFF_W-1:0] dx, dy;
	logic                    neg;

	// Offsets in half-texel units; row drives x, column drives y
	always_comb begin
		dx  = $signed(OFF_W'({row, 1'b0})) - TS_S;
		dy  = $signed(OFF_W'({column, 1'b0})) - TS_S;
		neg = dx < 0;
		cls.centre = (dx == 0) && (dy == 0);
		cls.axis   = (dy == 0);
		cls.x0     = neg ? -dx : dx;
		cls.y0     = neg ? -dy : dy;
		if (!neg) begin
			cls.base = BASE_ZERO;
		end else if (dy >= 0) begin
			cls.base = BASE_POS;
		end else begin
			cls.base = BASE_NEG;
		end
	end

	// Pass the transaction straight into the queue
	assign cls_valid   = texel_valid;
	assign texel_ready = cls_ready;
endmodule
`default_nettype wire

/* sv/hcw_queue.sv */
// Two-entry queue of classified texels between front and back end.
// Uses hcw_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module hcw_queue import hcw_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push_valid,
	output logic             push_ready,
	input  wire texel_cls_t  push_data,
	output logic             pop_valid,
	input  wire logic        pop_ready,
	output texel_cls_t       pop_data
);
	texel_cls_t ent_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = ent_q[rd_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_data;
	end

	`HCW_ASSERT(a_cnt_bound, cnt_q <= 2'd2, "queue count beyond depth")
	`HCW_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_q == $past(cnt_q) + 2'd1, "push lost")
	`HCW_ASSERT(a_ptr_sync, (cnt_q == 2'd1) == (wr_q != rd_q), "pointers disagree with count")
endmodule
`default_nettype wire

/* sv/hcw_back.sv */
// Back end: CORDIC, gain, saturation by reciprocal multiply and HSV-to-RGB pipeline.
// All stages advance together. Uses hcw_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module hcw_back import hcw_pkg::*; #(
	parameter int WHEEL_SIZE    = WHEEL_SIZE_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cls_valid,
	output logic                   cls_ready,
	input  wire texel_cls_t        cls,
	output logic                   color_valid,
	input  wire logic              color_ready,
	output logic [BYTE_W-1:0]      red,
	output logic [BYTE_W-1:0]      green,
	output logic [BYTE_W-1:0]      blue,
	output logic [BYTE_W-1:0]      alpha
);
	localparam int FB  = FRACTION_BITS;
	localparam int SW  = FB + 1;   // saturation / fraction
	localparam int HW  = FB + 3;   // hue, [0,6]
	localparam int CHW = FB + 3;   // signed channel
	localparam int RW  = CW + 1;   // magnitude width
	localparam int NS  = CORDIC_STEPS;

	// Reciprocal of the wheel size: exact floor division for dividends below 2^TW
	localparam int TW  = $clog2(2 * WHEEL_SIZE) + FB;
	localparam int LW  = TW / 2;
	localparam int HIW = TW - LW;
	localparam int RSH = TW + $clog2(WHEEL_SIZE);
	localparam int MW  = TW + 2;
	localparam logic [MW-1:0] RECIP = MW'(((64'd1 << RSH) + 64'(WHEEL_SIZE) - 64'd1)
	                                      / 64'(WHEEL_SIZE));

	localparam logic [RW-1:0] DIV_D  = RW'(WHEEL_SIZE) << GUARD_BITS;
	localparam logic [RW-1:0] DIV_D2 = DIV_D << 1;
	localparam logic signed [ZW-1:0] HALF_TURN = $signed(ZW'(3)) <<< ANGLE_BITS;
	localparam logic signed [ZW-1:0] FULL_TURN = $signed(ZW'(6)) <<< ANGLE_BITS;
	localparam logic [SW-1:0] ONE     = SW'(1) << FB;
	localparam logic [SW-1:0] SAT_MAX = '1;

	function automatic logic [BYTE_W-1:0] to_byte(input logic signed [CHW-1:0] ch);
		logic [SW-1:0]   cl;
		logic [FB+8:0]   ext;
		logic [FB+8:0]   prod;
		if (ch < 0) begin
			cl = '0;
		end else if (ch > $signed(CHW'(ONE))) begin
			cl = ONE;
		end else begin
			cl = SW'(ch);
		end
		ext  = (FB+9)'(cl);
		prod = (ext << 8) - ext;
		return BYTE_W'(prod >> FB);
	endfunction

	logic en;
	assign en        = !color_valid || color_ready;
	assign cls_ready = en;

	// ---------------- CORDIC ----------------
	logic signed [CW-1:0] cx_s [NS+1];
	logic signed [CW-1:0] cy_s [NS+1];
	logic signed [ZW-1:0] cz_s [NS+1];
	texel_cls_t           cc_s [NS+1];
	logic [NS:0]          cv_s;

	// Load the rotation start vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s[0] <= 1'b0;
		end else if (en) begin
			cv_s[0] <= cls_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0] <= CW'($signed(cls.x0)) <<< GUARD_BITS;
			cy_s[0] <= CW'($signed(cls.y0)) <<< GUARD_BITS;
			cz_s[0] <= '0;
			cc_s[0] <= cls;
		end
	end

	// One micro-rotation per stage
	for (genvar k = 0; k < NS; k++) begin : g_cordic
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[k+1] <= 1'b0;
			end else if (en) begin
				cv_s[k+1] <= cv_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (cy_s[k] > 0) begin
					cx_s[k+1] <= cx_s[k] + (cy_s[k] >>> k);
					cy_s[k+1] <= cy_s[k] - (cx_s[k] >>> k);
					cz_s[k+1] <= cz_s[k] + $signed(ZW'(ATAN_HUE[k]));
				end else begin
					cx_s[k+1] <= cx_s[k] - (cy_s[k] >>> k);
					cy_s[k+1] <= cy_s[k] + (cx_s[k] >>> k);
					cz_s[k+1] <= cz_s[k] - $signed(ZW'(ATAN_HUE[k]));
				end
				cc_s[k+1] <= cc_s[k];
			end
		end
	end

	// ---------------- gain and hue ----------------
	logic [CW+29:0]       gain_prod;
	logic signed [ZW-1:0] z_eff, base_v, hue24, hue24_cl;
	logic [RW-1:0]        mag_g_s;
	logic [HW-1:0]        hue_g_s;
	logic                 centre_g_s, vld_g_s;

	always_comb begin
		gain_prod = $unsigned(cx_s[NS]) * INV_GAIN_Q30;
		z_eff     = cc_s[NS].axis ? '0 : cz_s[NS];
		unique case (cc_s[NS].base)
			BASE_POS: base_v = HALF_TURN;
			BASE_NEG: base_v = -HALF_TURN;
			default:  base_v = '0;
		endcase
		hue24 = z_eff + base_v + HALF_TURN;
		if (hue24 < 0) begin
			hue24_cl = '0;
		end else if (hue24 > FULL_TURN) begin
			hue24_cl = FULL_TURN;
		end else begin
			hue24_cl = hue24;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_g_s <= 1'b0;
		end else if (en) begin
			vld_g_s <= cv_s[NS];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mag_g_s    <= cc_s[NS].axis ? (RW'($unsigned(cc_s[NS].x0)) << GUARD_BITS)
			                            : RW'(gain_prod >> 30);
			hue_g_s    <= HW'($unsigned(hue24_cl) >> (ANGLE_BITS - FB));
			centre_g_s <= cc_s[NS].centre;
		end
	end

	// ---------------- saturation, partial products of the reciprocal ----------------
	logic [RW+FB-1:0]  mag_sh;
	logic [TW-1:0]     dvd;
	logic              ovf_g;
	logic [LW+MW-1:0]  prl_m_s;
	logic [HIW+MW-1:0] prh_m_s;
	logic [HW-1:0]     hue_m_s;
	logic              ovf_m_s, cen_m_s, vld_m_s;

	// Below overflow, saturation is floor(((mag << FB) >> GUARD_BITS) / size)
	always_comb begin
		mag_sh = (RW+FB)'(mag_g_s) << FB;
		ovf_g  = mag_g_s >= DIV_D2;
		dvd    = ovf_g ? '0 : TW'(mag_sh >> GUARD_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m_s <= 1'b0;
		end else if (en) begin
			vld_m_s <= vld_g_s;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			prl_m_s <= (LW+MW)'(dvd[LW-1:0]) * (LW+MW)'(RECIP);
			prh_m_s <= (HIW+MW)'(dvd[TW-1:LW]) * (HIW+MW)'(RECIP);
			hue_m_s <= hue_g_s;
			ovf_m_s <= ovf_g;
			cen_m_s <= centre_g_s;
		end
	end

	// ---------------- saturation, sum and quotient ----------------
	logic [TW+MW-1:0] prod_sum;
	logic [SW-1:0]    quo;
	logic [SW-1:0]    sat_t_s;
	logic [HW-1:0]    hue_t_s;
	logic             cen_t_s, vld_t_s;

	always_comb begin
		prod_sum = ((TW+MW)'(prh_m_s) << LW) + (TW+MW)'(prl_m_s);
		quo      = SW'(prod_sum >> RSH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_t_s <= 1'b0;
		end else if (en) begin
			vld_t_s <= vld_m_s;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sat_t_s <= ovf_m_s ? SAT_MAX : quo;
			hue_t_s <= hue_m_s;
			cen_t_s <= cen_m_s;
		end
	end

	// ---------------- sector and products ----------------
	logic [SW-1:0]   sat_d, fr_d;
	logic [2:0]      sec_d;
	logic [2*SW-1:0] pb_full, pc_full;
	logic [SW-1:0]   sat_p_s, pb_p_s, pc_p_s;
	logic [2:0]      sec_p_s;
	logic            cen_p_s, vld_p_s;

	always_comb begin
		sat_d = sat_t_s;
		sec_d = 3'(hue_t_s >> FB);
		if (sec_d > SECTOR_5) sec_d = SECTOR_5;
		fr_d    = SW'(hue_t_s - (HW'(sec_d) << FB));
		pb_full = (2*SW)'(sat_d) * (2*SW)'(fr_d);
		pc_full = (2*SW)'(sat_d) * (2*SW)'(ONE - fr_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p_s <= 1'b0;
		end else if (en) begin
			vld_p_s <= vld_t_s;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sat_p_s <= sat_d;
			pb_p_s  <= SW'(pb_full >> FB);
			pc_p_s  <= SW'(pc_full >> FB);
			sec_p_s <= sec_d;
			cen_p_s <= cen_t_s;
		end
	end

	// ---------------- channel select and output register ----------------
	logic signed [CHW-1:0] ch_a, ch_b, ch_c, ch_one, ch_r, ch_g, ch_bl;

	always_comb begin
		ch_one = $signed(CHW'(ONE));
		ch_a   = ch_one - $signed(CHW'(sat_p_s));
		ch_b   = ch_one - $signed(CHW'(pb_p_s));
		ch_c   = ch_one - $signed(CHW'(pc_p_s));
		unique case (sec_p_s)
			SECTOR_0: begin ch_r = ch_one; ch_g = ch_c;   ch_bl = ch_a;   end
			SECTOR_1: begin ch_r = ch_b;   ch_g = ch_one; ch_bl = ch_a;   end
			SECTOR_2: begin ch_r = ch_a;   ch_g = ch_one; ch_bl = ch_c;   end
			SECTOR_3: begin ch_r = ch_a;   ch_g = ch_b;   ch_bl = ch_one; end
			SECTOR_4: begin ch_r = ch_c;   ch_g = ch_a;   ch_bl = ch_one; end
			default:  begin ch_r = ch_one; ch_g = ch_a;   ch_bl = ch_b;   end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_valid <= 1'b0;
		end else if (en) begin
			color_valid <= vld_p_s;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (cen_p_s) begin
				red   <= BYTE_MAX;
				green <= BYTE_MAX;
				blue  <= BYTE_MAX;
				alpha <= BYTE_MAX;
			end else begin
				red   <= to_byte(ch_r);
				green <= to_byte(ch_g);
				blue  <= to_byte(ch_bl);
				alpha <= (sat_p_s >= ONE) ? BYTE_MIN : BYTE_MAX;
			end
		end
	end

	// Channel summaries for the checks below
	logic any_full, any_zero;
	assign any_full = (red == BYTE_MAX) || (green == BYTE_MAX) || (blue == BYTE_MAX);
	assign any_zero = (red == BYTE_MIN) || (green == BYTE_MIN) || (blue == BYTE_MIN);

	`HCW_ASSERT(a_alpha_code, !color_valid || alpha == BYTE_MIN || alpha == BYTE_MAX, "alpha code")
	`HCW_ASSERT(a_full_value, !color_valid || any_full, "no channel at full value")
	`HCW_ASSERT(a_rim_zero, !(color_valid && alpha == BYTE_MIN) || any_zero, "rim lacks zero")
endmodule
`default_nettype wire

/* sv/hsv_color_wheel_texel_core.sv */
// Hue-wheel texel core: takes one texel (column, row) per clock and returns
// its RGBA byte color on an HSV wheel centered in the texture. One texel is
// accepted every cycle while the output side takes results. An accepted
// transaction is queued, then passes through the start-vector load,
// 24 CORDIC stages, the gain stage, a two-stage reciprocal multiply for the
// saturation, the sector products and the output register. A two-entry queue
// separates the classifying front end from the pipeline; when the output is
// held off the whole pipeline holds, the queue fills and the input stalls.
// Uses hcw_pkg, hcw_front, hcw_queue and hcw_back.
`default_nettype none
module hsv_color_wheel_texel_core import hcw_pkg::*; #(
	parameter int WHEEL_SIZE    = WHEEL_SIZE_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               texel_valid,
	output logic                    texel_ready,
	input  wire logic [COORD_W-1:0] column,
	input  wire logic [COORD_W-1:0] row,
	output logic                    color_valid,
	input  wire logic               color_ready,
	output logic [BYTE_W-1:0]       red,
	output logic [BYTE_W-1:0]       green,
	output logic [BYTE_W-1:0]       blue,
	output logic [BYTE_W-1:0]       alpha
);
	texel_cls_t f_cls, q_cls;
	logic       f_valid, f_ready, q_valid, q_ready;

	// Classify incoming transaction
	hcw_front #(.WHEEL_SIZE(WHEEL_SIZE)) u_front (
		.column      (column),
		.row         (row),
		.texel_valid (texel_valid),
		.texel_ready (texel_ready),
		.cls_valid   (f_valid),
		.cls         (f_cls),
		.cls_ready   (f_ready)
	);

	// Decouple front from back
	hcw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_cls),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_cls)
	);

	// Compute color
	hcw_back #(
		.WHEEL_SIZE    (WHEEL_SIZE),
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cls_valid   (q_valid),
		.cls_ready   (q_ready),
		.cls         (q_cls),
		.color_valid (color_valid),
		.color_ready (color_ready),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.alpha       (alpha)
	);
endmodule
`default_nettype wire
